// File: design/psfr_pkg.sv
package psfr_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 32;
    localparam int MAX_RESULTS         = 14;
    localparam int QUEUE_DEPTH         = 4;

    localparam logic [7:0] START_ONE_RST = 8'h42;
    localparam logic [7:0] START_TWO_RST = 8'h4D;

    // configuration register indexes
    localparam logic CFG_START_ONE = 1'b0;
    localparam logic CFG_START_TWO = 1'b1;

    // one classified payload event from the parser to the emitter
    typedef struct packed {
        logic       finish;    // frame end: ok/words/odd_tail valid, data unused
        logic       ok;        // checksum matched
        logic [3:0] words;     // data words to emit, already capped
        logic       odd_tail;  // final emitted word has only its high byte
        logic [7:0] data;      // payload byte to store
    } token_t;

endpackage

// File: design/psfr_front.sv
module psfr_front #(
    parameter int MAX_FRAME_BYTES = psfr_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        rx_byte,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data,
    output logic              tok_push,
    output psfr_pkg::token_t  tok,
    input  logic              tok_full
);
    import psfr_pkg::*;

    localparam int STORE_DEPTH = MAX_FRAME_BYTES - 4;
    localparam int LW          = $clog2(STORE_DEPTH + 1);

    typedef enum logic [4:0] {
        PH_HUNT     = 5'b00001,
        PH_START2   = 5'b00010,
        PH_LEN_HIGH = 5'b00100,
        PH_LEN_LOW  = 5'b01000,
        PH_PAYLOAD  = 5'b10000
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [7:0]      sb1_reg, sb2_reg;
    logic [7:0]      len_high_reg, len_high_next;
    logic [LW-1:0]   pay_len_reg, pay_len_next;
    logic [LW-1:0]   count_reg, count_next;
    logic [15:0]     sum_reg, sum_next;
    logic [7:0]      prev_reg;

    logic            accept;
    logic [15:0]     len16;
    logic [LW:0]     count_plus2;
    logic [LW-1:0]   data_bytes;
    logic [LW-1:0]   words_raw;
    logic [7:0]      words_raw8;
    logic [3:0]      words_cap;
    logic            capped;

    assign full   = tok_full;
    assign accept = push && !tok_full;
    assign len16  = {len_high_reg, rx_byte};

    assign count_plus2 = {1'b0, count_reg} + (LW + 1)'(2);
    assign data_bytes  = pay_len_reg - LW'(2);
    assign words_raw   = LW'(({1'b0, data_bytes} + (LW + 1)'(1)) >> 1);
    assign words_raw8  = 8'(words_raw);
    assign capped      = words_raw8 > 8'(MAX_RESULTS);
    assign words_cap   = capped ? 4'(MAX_RESULTS) : words_raw8[3:0];

    always_comb
    begin
        phase_next     = phase_reg;
        len_high_next  = len_high_reg;
        pay_len_next   = pay_len_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        tok_push       = 1'b0;
        tok.finish     = 1'b0;
        tok.ok         = ({prev_reg, rx_byte} == sum_reg);
        tok.words      = words_cap;
        tok.odd_tail   = data_bytes[0] && !capped;
        tok.data       = rx_byte;
        if (accept)
        begin
            case (phase_reg)
                PH_START2:
                begin
                    if (rx_byte == sb2_reg)
                    begin
                        sum_next   = sum_reg + 16'(rx_byte);
                        phase_next = PH_LEN_HIGH;
                    end
                end
                PH_LEN_HIGH:
                begin
                    len_high_next = rx_byte;
                    sum_next      = sum_reg + 16'(rx_byte);
                    phase_next    = PH_LEN_LOW;
                end
                PH_LEN_LOW:
                begin
                    sum_next       = sum_reg + 16'(rx_byte);
                    count_next     = '0;
                    pay_len_next   = LW'(len16);
                    if (len16 < 16'd2 || len16 > 16'(STORE_DEPTH))
                        phase_next = PH_HUNT;
                    else
                        phase_next = PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    // checksum bytes stay out of the running sum
                    if (count_plus2 < {1'b0, pay_len_reg})
                        sum_next = sum_reg + 16'(rx_byte);
                    count_next = count_reg + LW'(1);
                    tok_push   = 1'b1;
                    if (count_reg + LW'(1) == pay_len_reg)
                    begin
                        tok.finish = 1'b1;
                        phase_next = PH_HUNT;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    if (rx_byte == sb1_reg)
                    begin
                        sum_next   = 16'(rx_byte);
                        count_next = '0;
                        phase_next = PH_START2;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            sb1_reg       <= START_ONE_RST;
            sb2_reg       <= START_TWO_RST;
            len_high_reg  <= '0;
            pay_len_reg   <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            len_high_reg  <= len_high_next;
            pay_len_reg   <= pay_len_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_START_ONE)
                    sb1_reg <= cfg_data;
                else
                    sb2_reg <= cfg_data;
            end
        end
    end

    // previous byte forms the high half of the trailing checksum
    always_ff @(posedge clk)
    begin
        if (accept)
            prev_reg <= rx_byte;
    end

endmodule

// File: design/psfr_queue.sv
module psfr_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  psfr_pkg::token_t  wr_tok,
    output logic              q_full,
    input  logic              rd_en,
    output psfr_pkg::token_t  rd_tok,
    output logic              q_empty
);
    import psfr_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    token_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_wr, do_rd;

    assign q_full  = count_reg == CW'(QUEUE_DEPTH);
    assign q_empty = count_reg == '0;
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_tok  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + CW'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_tok;
    end

endmodule

// File: design/psfr_back.sv
module psfr_back #(
    parameter int MAX_FRAME_BYTES = psfr_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  psfr_pkg::token_t  tok,
    input  logic              tok_empty,
    output logic              tok_pop,
    output logic              empty,
    input  logic              pop,
    output logic              status,
    output logic [3:0]        word_index,
    output logic [15:0]       word_value,
    output logic              last
);
    import psfr_pkg::*;

    localparam int STORE_DEPTH = MAX_FRAME_BYTES - 4;
    localparam int BAW         = $clog2(STORE_DEPTH);
    localparam int EW          = (STORE_DEPTH + 1) / 2;
    localparam int WAW         = BAW - 1;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_READ = 4'b0010,
        B_EMIT = 4'b0100,
        B_ERR  = 4'b1000
    } bstate_t;

    bstate_t         state_reg, state_next;
    logic [BAW-1:0]  ptr_reg, ptr_next;
    logic [3:0]      k_reg, k_next;
    logic [3:0]      n_reg, n_next;
    logic            odd_reg, odd_next;

    // even bytes of each word in one bank, odd bytes in the other
    logic [7:0]      mem_even [EW];
    logic [7:0]      mem_odd  [EW];
    logic [7:0]      rd_even_reg, rd_odd_reg;

    logic            out_valid_reg, out_valid_next;
    logic            status_reg, status_next;
    logic [3:0]      index_reg, index_next;
    logic [15:0]     value_reg, value_next;
    logic            last_reg, last_next;

    logic            slot_free;
    logic            mem_we;
    logic            is_last;
    logic [WAW-1:0]  rd_addr;

    assign slot_free = !out_valid_reg || pop;
    assign is_last   = (k_reg + 4'd1) == n_reg;
    assign rd_addr   = WAW'(k_reg);

    assign empty      = !out_valid_reg;
    assign status     = status_reg;
    assign word_index = index_reg;
    assign word_value = value_reg;
    assign last       = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        odd_next       = odd_reg;
        tok_pop        = 1'b0;
        mem_we         = 1'b0;
        out_valid_next = out_valid_reg && !pop;
        status_next    = status_reg;
        index_next     = index_reg;
        value_next     = value_reg;
        last_next      = last_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!tok_empty)
                begin
                    tok_pop = 1'b1;
                    if (!tok.finish)
                    begin
                        mem_we   = 1'b1;
                        ptr_next = ptr_reg + BAW'(1);
                    end
                    else
                    begin
                        ptr_next = '0;
                        k_next   = '0;
                        n_next   = tok.words;
                        odd_next = tok.odd_tail;
                        if (!tok.ok)
                            state_next = B_ERR;
                        else if (tok.words != 4'd0)
                            state_next = B_READ;
                    end
                end
            end
            B_READ:
            begin
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = 1'b0;
                    index_next     = k_reg;
                    value_next     = {rd_even_reg, (is_last && odd_reg) ? 8'd0 : rd_odd_reg};
                    last_next      = is_last;
                    k_next         = k_reg + 4'd1;
                    state_next     = is_last ? B_IDLE : B_READ;
                end
            end
            B_ERR:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = 1'b1;
                    index_next     = 4'd0;
                    value_next     = 16'd0;
                    last_next      = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            ptr_reg       <= '0;
            k_reg         <= '0;
            n_reg         <= '0;
            odd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
            odd_reg       <= odd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        index_reg  <= index_next;
        value_reg  <= value_next;
        last_reg   <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            if (ptr_reg[0])
                mem_odd[ptr_reg[BAW-1:1]] <= tok.data;
            else
                mem_even[ptr_reg[BAW-1:1]] <= tok.data;
        end
        if (state_reg == B_READ)
        begin
            rd_even_reg <= mem_even[rd_addr];
            rd_odd_reg  <= mem_odd[rd_addr];
        end
    end

endmodule

// File: design/particle_sensor_frame_receiver_core.sv
// Particle sensor frame receiver.
// Input side is a queue: present rx_byte with push; a byte is taken on a
// clock edge where push is high and full is low. Results come out of a
// queue as well: while empty is low, status/word_index/word_value/last
// show the oldest result, and pop takes it.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 first start byte,
// 1 second start byte) and cfg_data; cfg_ready is always high.
// A byte is classified combinationally and handed to the emitter through
// a four-entry token queue. The emitter stores one payload byte per cycle
// while idle and takes no tokens while it emits a frame's results. At
// frame end each data word is read from both payload banks in a read
// state and registered in an emit state; a checksum error result is
// registered directly. The input takes a byte whenever the token queue has room.
// Reset: start bytes return to 0x42 and 0x4D, the parser hunts for the
// first start byte, both queues are empty; the payload store needs no
// clearing pass.
// A stalled result consumer holds the emitter; tokens then back up and
// full rises once the token queue holds four.
module particle_sensor_frame_receiver_core #(
    parameter int MAX_FRAME_BYTES = psfr_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic        status,
    output logic [3:0]  word_index,
    output logic [15:0] word_value,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import psfr_pkg::*;

    token_t  front_tok;
    token_t  back_tok;
    logic    tok_push;
    logic    tok_full;
    logic    tok_pop;
    logic    tok_empty;

    assign cfg_ready = 1'b1;

    psfr_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .rx_byte   (rx_byte),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tok_push  (tok_push),
        .tok       (front_tok),
        .tok_full  (tok_full)
    );

    psfr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tok_push),
        .wr_tok  (front_tok),
        .q_full  (tok_full),
        .rd_en   (tok_pop),
        .rd_tok  (back_tok),
        .q_empty (tok_empty)
    );

    psfr_back #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .tok        (back_tok),
        .tok_empty  (tok_empty),
        .tok_pop    (tok_pop),
        .empty      (empty),
        .pop        (pop),
        .status     (status),
        .word_index (word_index),
        .word_value (word_value),
        .last       (last)
    );

endmodule
